// ===== hw/rtl/clns_pkg.sv =====
// ----------------------------------------------------------------------------
// clns_pkg
// Types, command codes and timing constants shared by the character LCD
// nibble sequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package clns_pkg;

  localparam logic [3:0] ACT_INIT    = 4'd0;
  localparam logic [3:0] ACT_WRITE   = 4'd1;
  localparam logic [3:0] ACT_CLEAR   = 4'd2;
  localparam logic [3:0] ACT_HOME    = 4'd3;
  localparam logic [3:0] ACT_CURSOR  = 4'd4;
  localparam logic [3:0] ACT_CONTROL = 4'd5;
  localparam logic [3:0] ACT_ENTRY   = 4'd6;
  localparam logic [3:0] ACT_SCROLL  = 4'd7;
  localparam logic [3:0] ACT_GLYPH   = 4'd8;

  localparam logic REG_LINES  = 1'b0;
  localparam logic REG_FFLAGS = 1'b1;

  localparam logic [2:0] LINES_RESET  = 3'd2;
  localparam logic [4:0] FFLAGS_RESET = 5'd8;

  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_HOME      = 8'h02;
  localparam logic [7:0] CMD_ENTRY     = 8'h04;
  localparam logic [7:0] CMD_CONTROL   = 8'h08;
  localparam logic [7:0] CMD_SHIFT     = 8'h10;
  localparam logic [7:0] SHIFT_DISPLAY = 8'h08;
  localparam logic [7:0] SHIFT_RIGHT   = 8'h04;
  localparam logic [7:0] CMD_FUNCTION  = 8'h20;
  localparam logic [7:0] CMD_CGRAM     = 8'h40;
  localparam logic [7:0] CMD_DDRAM     = 8'h80;

  localparam logic [2:0] CTRL_INIT  = 3'h4;
  localparam logic [1:0] ENTRY_INIT = 2'h2;

  localparam logic [3:0] WAKE_NIBBLE = 4'h3;
  localparam logic [3:0] MODE_NIBBLE = 4'h2;
  localparam logic [3:0] LAST_INIT_NIBBLE = 4'd11;

  localparam logic [15:0] HOLD_PULSE     = 16'd1;
  localparam logic [15:0] HOLD_SETTLE    = 16'd100;
  localparam logic [15:0] HOLD_LONG      = 16'd2100;
  localparam logic [15:0] HOLD_POWER     = 16'd50000;
  localparam logic [15:0] HOLD_WAKE      = 16'd4600;
  localparam logic [15:0] HOLD_WAKE_LAST = 16'd250;

  typedef struct packed {
    logic       known;
    logic       init;
    logic       rs;
    logic [7:0] cmd;
    logic       long_settle;
  } req_t;

  typedef struct packed {
    logic [3:0]  nib;
    logic [15:0] settle;
  } nib_entry_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_POWER,
    SEQ_EN_LO,
    SEQ_EN_HI,
    SEQ_SETTLE
  } seq_state_t;

  function automatic logic [6:0] row_base(input logic [1:0] r);
    logic [6:0] b;
    case (r)
      2'd0:    b = 7'h00;
      2'd1:    b = 7'h40;
      2'd2:    b = 7'h14;
      default: b = 7'h54;
    endcase
    return b;
  endfunction

  function automatic nib_entry_t init_nibble(input logic [3:0] k, input logic [4:0] ff);
    nib_entry_t e;
    logic [7:0] fn_cmd;
    logic [7:0] ctl_cmd;
    logic [7:0] ent_cmd;
    fn_cmd  = CMD_FUNCTION | {3'b000, ff};
    ctl_cmd = CMD_CONTROL | {5'b00000, CTRL_INIT};
    ent_cmd = CMD_ENTRY | {6'b000000, ENTRY_INIT};
    case (k)
      4'd0:    e = '{nib: WAKE_NIBBLE, settle: HOLD_WAKE};
      4'd1:    e = '{nib: WAKE_NIBBLE, settle: HOLD_WAKE};
      4'd2:    e = '{nib: WAKE_NIBBLE, settle: HOLD_WAKE_LAST};
      4'd3:    e = '{nib: MODE_NIBBLE, settle: HOLD_SETTLE};
      4'd4:    e = '{nib: fn_cmd[7:4], settle: HOLD_SETTLE};
      4'd5:    e = '{nib: fn_cmd[3:0], settle: HOLD_SETTLE};
      4'd6:    e = '{nib: ctl_cmd[7:4], settle: HOLD_SETTLE};
      4'd7:    e = '{nib: ctl_cmd[3:0], settle: HOLD_SETTLE};
      4'd8:    e = '{nib: CMD_CLEAR[7:4], settle: HOLD_SETTLE};
      4'd9:    e = '{nib: CMD_CLEAR[3:0], settle: HOLD_LONG};
      4'd10:   e = '{nib: ent_cmd[7:4], settle: HOLD_SETTLE};
      default: e = '{nib: ent_cmd[3:0], settle: HOLD_SETTLE};
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/char_lcd_nibble_sequencer.sv =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer
// Character LCD driver for a 4-bit bus: turns requests into timed pin states.
// ----------------------------------------------------------------------------
// Each accepted request is sent as pin-state transactions, three per nibble
// (enable low, high, low), high nibble first. An init request gives 37 pin
// states and every other known request gives 6; unknown actions give none. The
// nibble sequencer loads one pin state per cycle while the output is not
// stalled; an unknown action never leaves the idle state. The in_stall output
// is high from the cycle after acceptance until the final pin state has been
// loaded into the output register; that state may still be waiting on
// out_stall when the next request is accepted.
// Registers: lines_in_use at address 0, function_flags at address 4.
`default_nettype none

module char_lcd_nibble_sequencer #(
  parameter int MAX_ROWS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  in_action,
  input  wire logic [7:0]  in_value,
  input  wire logic [6:0]  in_column,
  input  wire logic [2:0]  in_row,
  input  wire logic [1:0]  in_flag_select,
  input  wire logic        in_flag_value,
  input  wire logic        in_scroll_right,
  input  wire logic [2:0]  in_glyph_slot,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_reg_select,
  output logic             out_enable_level,
  output logic [3:0]       out_data_nibble,
  output logic [15:0]      out_hold_us,
  output logic             out_last
);
  import clns_pkg::*;

  logic [2:0] lines_r;
  logic [4:0] fflags_r;
  logic       busy;
  logic       start;
  logic       cfg_wr;
  req_t       req;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign in_stall = busy;
  assign start    = in_valid && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lines_r  <= LINES_RESET;
      fflags_r <= FFLAGS_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_LINES) begin
        lines_r <= pwdata[2:0];
      end else begin
        fflags_r <= pwdata[4:0];
      end
    end
  end

  always_comb begin
    case (paddr[2])
      REG_LINES: prdata = {29'd0, lines_r};
      default:   prdata = {27'd0, fflags_r};
    endcase
  end

  clns_cmd_decode #(
    .MAX_ROWS(MAX_ROWS)
  ) u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .action       (in_action),
    .value        (in_value),
    .column       (in_column),
    .row          (in_row),
    .flag_select  (in_flag_select),
    .flag_value   (in_flag_value),
    .scroll_right (in_scroll_right),
    .glyph_slot   (in_glyph_slot),
    .lines_in_use (lines_r),
    .req          (req)
  );

  clns_pin_seq u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .req              (req),
    .function_flags   (fflags_r),
    .busy             (busy),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_reg_select   (out_reg_select),
    .out_enable_level (out_enable_level),
    .out_data_nibble  (out_data_nibble),
    .out_hold_us      (out_hold_us),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/clns_cmd_decode.sv =====
// ----------------------------------------------------------------------------
// clns_cmd_decode
// Turns a request into the command byte to send and keeps the display-control
// and entry-mode flags.
// ----------------------------------------------------------------------------
`default_nettype none

module clns_cmd_decode #(
  parameter int MAX_ROWS = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [3:0]    action,
  input  wire logic [7:0]    value,
  input  wire logic [6:0]    column,
  input  wire logic [2:0]    row,
  input  wire logic [1:0]    flag_select,
  input  wire logic          flag_value,
  input  wire logic          scroll_right,
  input  wire logic [2:0]    glyph_slot,
  input  wire logic [2:0]    lines_in_use,
  output clns_pkg::req_t     req
);
  import clns_pkg::*;

  localparam logic [2:0] MaxLines = 3'(MAX_ROWS);

  logic [2:0] control_r, control_nxt;
  logic [1:0] entry_r, entry_nxt;
  logic [2:0] ctrl_mask;
  logic [1:0] entry_mask;
  logic [2:0] lines_eff;
  logic [2:0] row_c;
  logic [6:0] ddram_addr;

  always_comb begin
    case (flag_select)
      2'd0:    ctrl_mask = 3'h4;
      2'd1:    ctrl_mask = 3'h2;
      2'd2:    ctrl_mask = 3'h1;
      default: ctrl_mask = 3'h0;
    endcase
    case (flag_select)
      2'd0:    entry_mask = 2'h2;
      2'd1:    entry_mask = 2'h1;
      default: entry_mask = 2'h0;
    endcase
  end

  always_comb begin
    control_nxt = control_r;
    entry_nxt   = entry_r;
    case (action)
      ACT_INIT: begin
        control_nxt = CTRL_INIT;
        entry_nxt   = ENTRY_INIT;
      end
      ACT_CONTROL: begin
        control_nxt = flag_value ? (control_r | ctrl_mask) : (control_r & ~ctrl_mask);
      end
      ACT_ENTRY: begin
        entry_nxt = flag_value ? (entry_r | entry_mask) : (entry_r & ~entry_mask);
      end
      default: begin
        control_nxt = control_r;
      end
    endcase
  end

  always_comb begin
    if (lines_in_use == 3'd0) begin
      lines_eff = 3'd1;
    end else if (lines_in_use > MaxLines) begin
      lines_eff = MaxLines;
    end else begin
      lines_eff = lines_in_use;
    end
    row_c      = (row >= lines_eff) ? (lines_eff - 3'd1) : row;
    ddram_addr = column + row_base(row_c[1:0]);
  end

  always_comb begin
    req = '{known: 1'b1, init: 1'b0, rs: 1'b0, cmd: CMD_CLEAR, long_settle: 1'b0};
    case (action)
      ACT_INIT:    req.init = 1'b1;
      ACT_WRITE: begin
        req.rs  = 1'b1;
        req.cmd = value;
      end
      ACT_CLEAR:   req.long_settle = 1'b1;
      ACT_HOME: begin
        req.cmd         = CMD_HOME;
        req.long_settle = 1'b1;
      end
      ACT_CURSOR:  req.cmd = CMD_DDRAM | {1'b0, ddram_addr};
      ACT_CONTROL: req.cmd = CMD_CONTROL | {5'b00000, control_nxt};
      ACT_ENTRY:   req.cmd = CMD_ENTRY | {6'b000000, entry_nxt};
      ACT_SCROLL:  req.cmd = CMD_SHIFT | SHIFT_DISPLAY | (scroll_right ? SHIFT_RIGHT : 8'h00);
      ACT_GLYPH:   req.cmd = CMD_CGRAM | {2'b00, glyph_slot, 3'b000};
      default:     req.known = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      control_r <= 3'h0;
      entry_r   <= 2'h0;
    end else if (start) begin
      control_r <= control_nxt;
      entry_r   <= entry_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/clns_pin_seq.sv =====
// ----------------------------------------------------------------------------
// clns_pin_seq
// Steps through the nibbles of a request and emits one timed pin state per
// transaction: enable low, enable high, enable low with settle time.
// ----------------------------------------------------------------------------
`default_nettype none

module clns_pin_seq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire clns_pkg::req_t req,
  input  wire logic [4:0]    function_flags,
  output logic               busy,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic               out_reg_select,
  output logic               out_enable_level,
  output logic [3:0]         out_data_nibble,
  output logic [15:0]        out_hold_us,
  output logic               out_last
);
  import clns_pkg::*;

  seq_state_t state_r, state_nxt;
  logic [3:0] nib_idx_r, nib_idx_nxt;
  req_t       req_r;
  logic [4:0] ff_r;
  logic       out_valid_r, out_valid_nxt;
  logic       rs_r, en_r, last_r;
  logic [3:0] nib_r;
  logic [15:0] hold_r;

  logic        load;
  logic        last_nib;
  nib_entry_t  cur;
  nib_entry_t  init_e;
  logic        pin_en, pin_last;
  logic [3:0]  pin_nib;
  logic [15:0] pin_hold;

  assign load     = !out_valid_r || !out_stall;
  assign busy     = (state_r != SEQ_IDLE);
  assign last_nib = req_r.init ? (nib_idx_r == LAST_INIT_NIBBLE) : nib_idx_r[0];
  assign init_e   = init_nibble(nib_idx_r, ff_r);

  always_comb begin
    if (req_r.init) begin
      cur = init_e;
    end else if (nib_idx_r[0]) begin
      cur = '{nib: req_r.cmd[3:0], settle: req_r.long_settle ? HOLD_LONG : HOLD_SETTLE};
    end else begin
      cur = '{nib: req_r.cmd[7:4], settle: HOLD_SETTLE};
    end
  end

  always_comb begin
    state_nxt   = state_r;
    nib_idx_nxt = nib_idx_r;
    case (state_r)
      SEQ_IDLE: begin
        if (start && req.known) begin
          state_nxt   = req.init ? SEQ_POWER : SEQ_EN_LO;
          nib_idx_nxt = 4'd0;
        end
      end
      SEQ_POWER:  if (load) state_nxt = SEQ_EN_LO;
      SEQ_EN_LO:  if (load) state_nxt = SEQ_EN_HI;
      SEQ_EN_HI:  if (load) state_nxt = SEQ_SETTLE;
      SEQ_SETTLE: begin
        if (load) begin
          if (last_nib) begin
            state_nxt = SEQ_IDLE;
          end else begin
            state_nxt   = SEQ_EN_LO;
            nib_idx_nxt = nib_idx_r + 4'd1;
          end
        end
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  always_comb begin
    pin_en   = 1'b0;
    pin_nib  = cur.nib;
    pin_hold = HOLD_PULSE;
    pin_last = 1'b0;
    case (state_r)
      SEQ_POWER: begin
        pin_nib  = 4'h0;
        pin_hold = HOLD_POWER;
      end
      SEQ_EN_HI: pin_en = 1'b1;
      SEQ_SETTLE: begin
        pin_hold = cur.settle;
        pin_last = last_nib;
      end
      default: pin_en = 1'b0;
    endcase
  end

  assign out_valid_nxt = load ? busy : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SEQ_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nib_idx_r <= nib_idx_nxt;
    if (start) begin
      req_r <= req;
      ff_r  <= function_flags;
    end
    if (load && busy) begin
      rs_r   <= req_r.rs;
      en_r   <= pin_en;
      nib_r  <= pin_nib;
      hold_r <= pin_hold;
      last_r <= pin_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_reg_select   = rs_r;
  assign out_enable_level = en_r;
  assign out_data_nibble  = nib_r;
  assign out_hold_us      = hold_r;
  assign out_last         = last_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == SEQ_IDLE)
    else $error("request started while the sequencer was busy");

  a_last_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && last_r |-> !en_r)
    else $error("final pin state has enable high");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != SEQ_IDLE && !req_r.init |-> nib_idx_r <= 4'd1)
    else $error("nibble index past the end of a single-byte request");

endmodule

`default_nettype wire

// ===== dv/tb_char_lcd_nibble_sequencer.sv =====
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_sequencer
// Self-checking testbench for the character LCD nibble sequencer.
// ----------------------------------------------------------------------------
// Requests are driven over the valid/stall input channel in bursts with random
// gaps, while the pin-state channel stalls on a pattern of its own. A
// scoreboard predicts the pin-state transactions of every accepted request,
// tracking the control and entry flags and the two registers, and checks each
// accepted pin state against the oldest prediction. A directed part covers
// every action, the field extremes, unused flag selects, unknown actions and
// the row clamp; random phases follow under several register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_char_lcd_nibble_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  import clns_pkg::*;

  localparam int          TB_MAX_ROWS     = 4;
  localparam int          IDLE_SETTLE     = 50;
  localparam int          LONG_HOLD_CYCLES = 400;
  localparam int          PHASE_ITEMS     = 48;
  localparam logic [3:0]  ACT_UNKNOWN_LO  = 4'd9;
  localparam logic [3:0]  ACT_UNKNOWN_HI  = 4'd15;

  typedef struct packed {
    logic [3:0] action;
    logic [7:0] value;
    logic [6:0] column;
    logic [2:0] row;
    logic [1:0] flag_select;
    logic       flag_value;
    logic       scroll_right;
    logic [2:0] glyph_slot;
  } lcd_request_t;

  typedef struct packed {
    logic        reg_select;
    logic        enable_level;
    logic [3:0]  data_nibble;
    logic [15:0] hold_us;
    logic        last;
  } pin_state_t;

  class lcd_pin_scoreboard;
    pin_state_t expected_pins[$];
    int         errors;
    logic [2:0] lines_reg;
    logic [4:0] fflags_reg;
    logic [2:0] ctrl_bits;
    logic [1:0] entry_bits;

    function new();
      errors     = 0;
      lines_reg  = LINES_RESET;
      fflags_reg = FFLAGS_RESET;
      ctrl_bits  = 3'b000;
      entry_bits = 2'b00;
    endfunction

    function void set_register(input logic idx, input logic [31:0] data);
      if (idx == REG_LINES) begin
        lines_reg = data[2:0];
      end else begin
        fflags_reg = data[4:0];
      end
    endfunction

    function int pending_count();
      return expected_pins.size();
    endfunction

    function void add_state(input logic rs, input logic en, input logic [3:0] nib,
                            input logic [15:0] hold);
      pin_state_t p;
      p.reg_select   = rs;
      p.enable_level = en;
      p.data_nibble  = nib;
      p.hold_us      = hold;
      p.last         = 1'b0;
      expected_pins.push_back(p);
    endfunction

    function void add_nibble(input logic rs, input logic [3:0] nib, input logic [15:0] settle);
      add_state(rs, 1'b0, nib, HOLD_PULSE);
      add_state(rs, 1'b1, nib, HOLD_PULSE);
      add_state(rs, 1'b0, nib, settle);
    endfunction

    function void add_byte(input logic rs, input logic [7:0] b, input logic [15:0] settle);
      add_nibble(rs, b[7:4], HOLD_SETTLE);
      add_nibble(rs, b[3:0], settle);
    endfunction

    function void note_request(input lcd_request_t r);
      int         first_new;
      int         lines;
      int         row_eff;
      logic [2:0] ctrl_mask;
      logic [1:0] entry_mask;
      logic [6:0] base;
      logic [6:0] addr;
      first_new = expected_pins.size();
      case (r.action)
        ACT_INIT: begin
          add_state(1'b0, 1'b0, 4'h0, HOLD_POWER);
          add_nibble(1'b0, WAKE_NIBBLE, HOLD_WAKE);
          add_nibble(1'b0, WAKE_NIBBLE, HOLD_WAKE);
          add_nibble(1'b0, WAKE_NIBBLE, HOLD_WAKE_LAST);
          add_nibble(1'b0, MODE_NIBBLE, HOLD_SETTLE);
          add_byte(1'b0, CMD_FUNCTION | {3'b000, fflags_reg}, HOLD_SETTLE);
          ctrl_bits = CTRL_INIT;
          add_byte(1'b0, CMD_CONTROL | {5'b00000, ctrl_bits}, HOLD_SETTLE);
          add_byte(1'b0, CMD_CLEAR, HOLD_LONG);
          entry_bits = ENTRY_INIT;
          add_byte(1'b0, CMD_ENTRY | {6'b000000, entry_bits}, HOLD_SETTLE);
        end
        ACT_WRITE: add_byte(1'b1, r.value, HOLD_SETTLE);
        ACT_CLEAR: add_byte(1'b0, CMD_CLEAR, HOLD_LONG);
        ACT_HOME:  add_byte(1'b0, CMD_HOME, HOLD_LONG);
        ACT_CURSOR: begin
          lines = int'(lines_reg);
          if (lines < 1) lines = 1;
          if (lines > TB_MAX_ROWS) lines = TB_MAX_ROWS;
          row_eff = (int'(r.row) >= lines) ? lines - 1 : int'(r.row);
          case (row_eff)
            0:       base = 7'h00;
            1:       base = 7'h40;
            2:       base = 7'h14;
            default: base = 7'h54;
          endcase
          addr = r.column + base;
          add_byte(1'b0, CMD_DDRAM | {1'b0, addr}, HOLD_SETTLE);
        end
        ACT_CONTROL: begin
          case (r.flag_select)
            2'd0:    ctrl_mask = 3'h4;
            2'd1:    ctrl_mask = 3'h2;
            2'd2:    ctrl_mask = 3'h1;
            default: ctrl_mask = 3'h0;
          endcase
          ctrl_bits = r.flag_value ? (ctrl_bits | ctrl_mask) : (ctrl_bits & ~ctrl_mask);
          add_byte(1'b0, CMD_CONTROL | {5'b00000, ctrl_bits}, HOLD_SETTLE);
        end
        ACT_ENTRY: begin
          case (r.flag_select)
            2'd0:    entry_mask = 2'h2;
            2'd1:    entry_mask = 2'h1;
            default: entry_mask = 2'h0;
          endcase
          entry_bits = r.flag_value ? (entry_bits | entry_mask) : (entry_bits & ~entry_mask);
          add_byte(1'b0, CMD_ENTRY | {6'b000000, entry_bits}, HOLD_SETTLE);
        end
        ACT_SCROLL: add_byte(1'b0, CMD_SHIFT | SHIFT_DISPLAY | (r.scroll_right ? SHIFT_RIGHT : 8'h00),
                             HOLD_SETTLE);
        ACT_GLYPH:  add_byte(1'b0, CMD_CGRAM | {2'b00, r.glyph_slot, 3'b000}, HOLD_SETTLE);
        default: ;
      endcase
      if (expected_pins.size() > first_new) begin
        expected_pins[expected_pins.size() - 1].last = 1'b1;
      end
    endfunction

    function void compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_pin_state(input pin_state_t got);
      pin_state_t want;
      if (expected_pins.size() == 0) begin
        $display("%0t: unexpected pin state, expected none, actual rs=%0d en=%0d nib=%0d hold=%0d last=%0d",
                 $time, got.reg_select, got.enable_level, got.data_nibble, got.hold_us, got.last);
        errors++;
        return;
      end
      want = expected_pins.pop_front();
      compare_field("reg_select", 16'(want.reg_select), 16'(got.reg_select));
      compare_field("enable_level", 16'(want.enable_level), 16'(got.enable_level));
      compare_field("data_nibble", 16'(want.data_nibble), 16'(got.data_nibble));
      compare_field("hold_us", want.hold_us, got.hold_us);
      compare_field("last", 16'(want.last), 16'(got.last));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic [3:0]  in_action;
  logic [7:0]  in_value;
  logic [6:0]  in_column;
  logic [2:0]  in_row;
  logic [1:0]  in_flag_select;
  logic        in_flag_value;
  logic        in_scroll_right;
  logic [2:0]  in_glyph_slot;
  logic        out_valid;
  logic        out_stall;
  logic        out_reg_select;
  logic        out_enable_level;
  logic [3:0]  out_data_nibble;
  logic [15:0] out_hold_us;
  logic        out_last;

  lcd_pin_scoreboard sb;
  bit                hold_off_request;

  char_lcd_nibble_sequencer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_value         (in_value),
    .in_column        (in_column),
    .in_row           (in_row),
    .in_flag_select   (in_flag_select),
    .in_flag_value    (in_flag_value),
    .in_scroll_right  (in_scroll_right),
    .in_glyph_slot    (in_glyph_slot),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_reg_select   (out_reg_select),
    .out_enable_level (out_enable_level),
    .out_data_nibble  (out_data_nibble),
    .out_hold_us      (out_hold_us),
    .out_last         (out_last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_pin_state({out_reg_select, out_enable_level, out_data_nibble, out_hold_us,
                          out_last});
    end
  end

  initial begin
    int seg;
    int pct;
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      seg = $urandom_range(4, 80);
      case ($urandom_range(0, 3))
        0:       pct = 0;
        1:       pct = 20;
        2:       pct = 50;
        default: pct = 80;
      endcase
      repeat (seg) begin
        @(negedge clk);
        if (hold_off_request) begin
          hold_off_request = 1'b0;
          hold_left = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
          out_stall = 1'b1;
          hold_left--;
        end else begin
          out_stall = ($urandom_range(0, 99) < pct);
        end
      end
    end
  end

  function automatic lcd_request_t make_request(input logic [3:0] action, input logic [7:0] value,
                                                input logic [6:0] column, input logic [2:0] row,
                                                input logic [1:0] sel, input logic fv,
                                                input logic right, input logic [2:0] slot);
    lcd_request_t r;
    r.action       = action;
    r.value        = value;
    r.column       = column;
    r.row          = row;
    r.flag_select  = sel;
    r.flag_value   = fv;
    r.scroll_right = right;
    r.glyph_slot   = slot;
    return r;
  endfunction

  function automatic lcd_request_t random_request(input logic [3:0] action);
    return make_request(action, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                        3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        3'($urandom_range(0, 7)));
  endfunction

  function automatic logic [3:0] pick_action();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return ACT_INIT;
    if (r < 34) return ACT_WRITE;
    if (r < 40) return ACT_CLEAR;
    if (r < 46) return ACT_HOME;
    if (r < 60) return ACT_CURSOR;
    if (r < 72) return ACT_CONTROL;
    if (r < 82) return ACT_ENTRY;
    if (r < 88) return ACT_SCROLL;
    if (r < 94) return ACT_GLYPH;
    return 4'($urandom_range(ACT_UNKNOWN_LO, ACT_UNKNOWN_HI));
  endfunction

  task automatic drive_request(input lcd_request_t r);
    in_action       = r.action;
    in_value        = r.value;
    in_column       = r.column;
    in_row          = r.row;
    in_flag_select  = r.flag_select;
    in_flag_value   = r.flag_value;
    in_scroll_right = r.scroll_right;
    in_glyph_slot   = r.glyph_slot;
  endtask

  task automatic push_requests(input lcd_request_t reqs[$], input int drain_at);
    int idx;
    int burst;
    int gap;
    bit steady;
    idx = 0;
    steady = ($urandom_range(0, 3) == 0);
    while (idx < reqs.size()) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && idx < reqs.size()) begin
        if (idx == drain_at) begin
          @(negedge clk);
          in_valid = 1'b0;
          while (sb.pending_count() != 0) @(posedge clk);
        end
        @(negedge clk);
        drive_request(reqs[idx]);
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
        sb.note_request(reqs[idx]);
        idx++;
        burst--;
      end
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(idx, data);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_config(input logic [2:0] lines_v, input logic [4:0] ff_v);
    write_reg(REG_LINES, ($urandom() & 32'hFFFF_FFF8) | {29'd0, lines_v});
    write_reg(REG_FFLAGS, ($urandom() & 32'hFFFF_FFE0) | {27'd0, ff_v});
  endtask

  task automatic wait_idle();
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  initial begin
    lcd_request_t reqs[$];
    logic [2:0]   lines_v;
    logic [4:0]   ff_v;
    sb = new();
    hold_off_request = 1'b0;
    rst_n    = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    in_valid = 1'b0;
    drive_request(make_request(ACT_INIT, 8'h00, 7'h00, 3'd0, 2'd0, 1'b0, 1'b0, 3'd0));
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    reqs.push_back(make_request(ACT_WRITE, 8'hA5, 7'h00, 3'd0, 2'd0, 1'b0, 1'b0, 3'd0));
    reqs.push_back(make_request(ACT_INIT, 8'h00, 7'h00, 3'd0, 2'd0, 1'b0, 1'b0, 3'd0));
    reqs.push_back(make_request(ACT_WRITE, 8'h00, 7'h00, 3'd0, 2'd0, 1'b0, 1'b0, 3'd0));
    reqs.push_back(make_request(ACT_WRITE, 8'hFF, 7'h7F, 3'd7, 2'd3, 1'b1, 1'b1, 3'd7));
    reqs.push_back(make_request(ACT_CLEAR, 8'h00, 7'h00, 3'd0, 2'd0, 1'b0, 1'b0, 3'd0));
    reqs.push_back(make_request(ACT_HOME, 8'h00, 7'h00, 3'd0, 2'd0, 1'b0, 1'b0, 3'd0));
    reqs.push_back(make_request(ACT_CURSOR, 8'h00, 7'h00, 3'd0, 2'd0, 1'b0, 1'b0, 3'd0));
    reqs.push_back(make_request(ACT_CURSOR, 8'h00, 7'h7F, 3'd7, 2'd0, 1'b0, 1'b0, 3'd0));
    reqs.push_back(make_request(ACT_CONTROL, 8'h00, 7'h00, 3'd0, 2'd0, 1'b0, 1'b0, 3'd0));
    reqs.push_back(make_request(ACT_CONTROL, 8'h00, 7'h00, 3'd0, 2'd1, 1'b1, 1'b0, 3'd0));
    reqs.push_back(make_request(ACT_CONTROL, 8'h00, 7'h00, 3'd0, 2'd2, 1'b1, 1'b0, 3'd0));
    reqs.push_back(make_request(ACT_CONTROL, 8'h00, 7'h00, 3'd0, 2'd3, 1'b1, 1'b0, 3'd0));
    reqs.push_back(make_request(ACT_ENTRY, 8'h00, 7'h00, 3'd0, 2'd0, 1'b0, 1'b0, 3'd0));
    reqs.push_back(make_request(ACT_ENTRY, 8'h00, 7'h00, 3'd0, 2'd1, 1'b1, 1'b0, 3'd0));
    reqs.push_back(make_request(ACT_ENTRY, 8'h00, 7'h00, 3'd0, 2'd2, 1'b1, 1'b0, 3'd0));
    reqs.push_back(make_request(ACT_ENTRY, 8'h00, 7'h00, 3'd0, 2'd3, 1'b0, 1'b0, 3'd0));
    reqs.push_back(make_request(ACT_SCROLL, 8'h00, 7'h00, 3'd0, 2'd0, 1'b0, 1'b0, 3'd0));
    reqs.push_back(make_request(ACT_SCROLL, 8'h00, 7'h00, 3'd0, 2'd0, 1'b0, 1'b1, 3'd0));
    reqs.push_back(make_request(ACT_GLYPH, 8'h00, 7'h00, 3'd0, 2'd0, 1'b0, 1'b0, 3'd0));
    reqs.push_back(make_request(ACT_GLYPH, 8'h00, 7'h00, 3'd0, 2'd0, 1'b0, 1'b0, 3'd7));
    reqs.push_back(make_request(ACT_UNKNOWN_LO, 8'hFF, 7'h7F, 3'd7, 2'd3, 1'b1, 1'b1, 3'd7));
    reqs.push_back(make_request(ACT_UNKNOWN_HI, 8'h00, 7'h00, 3'd0, 2'd0, 1'b0, 1'b0, 3'd0));
    push_requests(reqs, -1);

    wait_idle();
    set_config(3'd0, 5'd31);
    reqs.delete();
    reqs.push_back(make_request(ACT_CURSOR, 8'h00, 7'h64, 3'd5, 2'd0, 1'b0, 1'b0, 3'd0));
    reqs.push_back(make_request(ACT_INIT, 8'h00, 7'h00, 3'd0, 2'd0, 1'b0, 1'b0, 3'd0));
    push_requests(reqs, -1);

    wait_idle();
    set_config(3'd7, 5'd0);
    reqs.delete();
    reqs.push_back(make_request(ACT_CURSOR, 8'h00, 7'h7F, 3'd7, 2'd0, 1'b0, 1'b0, 3'd0));
    reqs.push_back(make_request(ACT_INIT, 8'h00, 7'h00, 3'd0, 2'd0, 1'b0, 1'b0, 3'd0));
    push_requests(reqs, -1);

    for (int phase = 0; phase < 5; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          lines_v = 3'd4;
          ff_v    = 5'd8;
        end
        1: begin
          lines_v = 3'd1;
          ff_v    = 5'd31;
        end
        default: begin
          lines_v = 3'($urandom_range(0, 7));
          ff_v    = 5'($urandom_range(0, 31));
        end
      endcase
      set_config(lines_v, ff_v);
      reqs.delete();
      while (reqs.size() < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          reqs.push_back(random_request(ACT_GLYPH));
          repeat (8) reqs.push_back(random_request(ACT_WRITE));
        end else begin
          reqs.push_back(random_request(pick_action()));
        end
      end
      if (phase == 2) hold_off_request = 1'b1;
      push_requests(reqs, (phase == 3) ? PHASE_ITEMS / 2 : -1);
    end

    while (sb.pending_count() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/clns_pkg.sv
hw/rtl/clns_cmd_decode.sv
hw/rtl/clns_pin_seq.sv
hw/rtl/char_lcd_nibble_sequencer.sv
dv/tb_char_lcd_nibble_sequencer.sv
